// ----- rtl/core/asl_pkg.sv -----
// Shared types, constants and helper functions for the assembly source lexer.
`default_nettype none

package asl_pkg;

    // Defaults for the top-level parameters
    localparam int TEXT_CHARS_DEF    = 8;
    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Token classes; KIND_SPACE never leaves the block
    typedef enum logic [3:0] {
        KIND_DIGIT    = 4'd0,
        KIND_LETTER   = 4'd1,
        KIND_COMMA    = 4'd2,
        KIND_LSQB     = 4'd3,
        KIND_RSQB     = 4'd4,
        KIND_COLON    = 4'd5,
        KIND_MINUS    = 4'd6,
        KIND_NEWLINE  = 4'd7,
        KIND_INVALID  = 4'd8,
        KIND_OPCODE   = 4'd9,
        KIND_REGISTER = 4'd10,
        KIND_CONSTANT = 4'd11,
        KIND_LABEL    = 4'd12,
        KIND_END      = 4'd13,
        KIND_SPACE    = 4'd15
    } asl_kind_t;

    // Open-run state of the front end
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_ALNUM = 2'd1,
        MODE_DIGIT = 2'd2
    } asl_mode_t;

    // Punctuation codes
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LSQB  = 8'h5B;
    localparam logic [7:0] CH_RSQB  = 8'h5D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Input beat
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } asl_in_t;

    // Output beat
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] token_text;
        logic [7:0]  token_length;
        logic [15:0] column_start;
        logic [15:0] column_end;
        logic [15:0] line_number;
        logic        last_token;
    } asl_out_t;

    // Keyword tables, first character in the low byte, unused bytes zero
    localparam int OPCODE_COUNT   = 12;
    localparam int REGISTER_COUNT = 4;

    localparam logic [31:0] OPCODE_WORDS [OPCODE_COUNT] = '{
        {8'h00, "K", "R", "H"},
        {8'h00, "P", "O", "T"},
        {8'h00, "K", "I", "C"},
        {8'h00, "P", "R", "C"},
        {8'h00, "L", "O", "B"},
        {8'h00, "G", "E", "D"},
        {8'h00, 8'h00, "E", "V"},
        {"A", "Y", "E", "V"},
        {8'h00, 8'h00, "S", "S"},
        {8'h00, "D", "S", "S"},
        {8'h00, 8'h00, "N", "S"},
        {8'h00, 8'h00, "P", "S"}
    };

    localparam logic [7:0] OPCODE_LENS [OPCODE_COUNT] = '{
        8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd2, 8'd4, 8'd2, 8'd3, 8'd2, 8'd2
    };

    localparam logic [31:0] REGISTER_WORDS [REGISTER_COUNT] = '{
        {8'h00, 8'h00, "X", "A"},
        {8'h00, 8'h00, "X", "B"},
        {8'h00, 8'h00, "X", "C"},
        {8'h00, 8'h00, "X", "D"}
    };

    // Width of one front-to-back bundle (see the bundle_t layout in front/back)
    function automatic int bundle_bits(input int text_chars, input int pos_bits);
        return 24 + 8 * text_chars + 6 * pos_bits;
    endfunction

    function automatic asl_kind_t classify_byte(input logic [7:0] b);
        asl_kind_t k;
        if (b >= "0" && b <= "9") begin
            k = KIND_DIGIT;
        end else if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
            k = KIND_LETTER;
        end else begin
            unique case (b) inside
                CH_COMMA:     k = KIND_COMMA;
                CH_LSQB:      k = KIND_LSQB;
                CH_RSQB:      k = KIND_RSQB;
                CH_COLON:     k = KIND_COLON;
                CH_MINUS:     k = KIND_MINUS;
                CH_LF, CH_CR: k = KIND_NEWLINE;
                CH_SPACE:     k = KIND_SPACE;
                default:      k = KIND_INVALID;
            endcase
        end
        return k;
    endfunction

    function automatic logic is_opcode(input logic [31:0] txt, input logic [7:0] len);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < OPCODE_COUNT; i++) begin
            if (len == OPCODE_LENS[i] && txt == OPCODE_WORDS[i]) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic is_register(input logic [31:0] txt, input logic [7:0] len);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < REGISTER_COUNT; i++) begin
            if (len == 8'd2 && txt == REGISTER_WORDS[i]) hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/asl_queue.sv -----
// Small register FIFO between lexer front end and token back end.
`default_nettype none

module asl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output      logic [WIDTH-1:0] rd_data,
    output      logic             empty,
    output      logic             full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/asl_front.sv -----
// Lexer front end: byte classification, run tracking, token bundle build.
`default_nettype none

module asl_front #(
    parameter int TEXT_CHARS    = asl_pkg::TEXT_CHARS_DEF,
    parameter int POSITION_BITS = asl_pkg::POSITION_BITS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output      logic            s_ready,
    input  wire asl_pkg::asl_in_t s_data,
    output      logic            push,
    output      logic [asl_pkg::bundle_bits(TEXT_CHARS, POSITION_BITS)-1:0] push_data,
    input  wire logic            q_full
);

    import asl_pkg::*;

    localparam int TB = TEXT_CHARS * 8;
    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = '1;

    typedef struct packed {
        logic          run_v;
        logic          run_digit;
        logic [TB-1:0] run_text;
        logic [7:0]    run_len;
        logic [PB-1:0] run_start;
        logic [PB-1:0] run_end;
        logic [PB-1:0] line_pre;
        logic          chr_v;
        asl_kind_t     chr_kind;
        logic [7:0]    chr_code;
        logic [PB-1:0] pos;
        logic [PB-1:0] line_post;
        logic          end_v;
        logic [PB-1:0] end_pos;
    } bundle_t;

    asl_mode_t     mode_reg, mode_next;
    logic [TB-1:0] text_reg, text_next;
    logic [7:0]    len_reg, len_next;
    logic [PB-1:0] start_reg, start_next;
    logic [PB-1:0] offset_reg, offset_next;
    logic [PB-1:0] line_reg, line_next;

    asl_kind_t     cls;
    logic          accept, eoi;
    logic          extend, close_run, starts_run, single;
    logic [TB-1:0] app_text, sel_text;
    logic [7:0]    app_len, sel_len;
    logic [PB:0]   end_sum;
    logic [PB-1:0] pos_inc, line_inc, line_post;
    bundle_t       bnd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign eoi     = s_data.end_of_input;

    always_comb begin
        cls = classify_byte(s_data.char_code);

        extend = (mode_reg == MODE_ALNUM && (cls == KIND_LETTER || cls == KIND_DIGIT))
              || (mode_reg == MODE_DIGIT && cls == KIND_DIGIT);
        close_run  = (mode_reg != MODE_NONE) && !extend;
        starts_run = !extend && (cls == KIND_LETTER || cls == KIND_DIGIT || cls == KIND_MINUS);
        single     = !extend && !starts_run && cls != KIND_SPACE;

        // append at the current length; only the first TEXT_CHARS bytes are kept
        app_text = text_reg;
        for (int i = 0; i < TEXT_CHARS; i++) begin
            if (len_reg == 8'(i)) app_text[8*i +: 8] = s_data.char_code;
        end
        app_len = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;

        pos_inc   = (offset_reg == POS_MAX) ? offset_reg : offset_reg + PB'(1);
        line_inc  = (line_reg == POS_MAX) ? line_reg : line_reg + PB'(1);
        line_post = (single && cls == KIND_NEWLINE) ? line_inc : line_reg;

        // closed run, or the run still growing when the source ends
        sel_text = close_run ? text_reg : app_text;
        sel_len  = close_run ? len_reg : app_len;
        end_sum  = {1'b0, start_reg} + (PB+1)'(sel_len) - (PB+1)'(1);

        bnd.run_v     = close_run || (extend && eoi);
        bnd.run_digit = (mode_reg == MODE_DIGIT);
        bnd.run_text  = sel_text;
        bnd.run_len   = sel_len;
        bnd.run_start = start_reg;
        bnd.run_end   = (end_sum > {1'b0, POS_MAX}) ? POS_MAX : end_sum[PB-1:0];
        bnd.line_pre  = line_reg;
        // a run opened by the final byte goes out as a one-character token
        bnd.chr_v     = single || (starts_run && eoi);
        bnd.chr_kind  = cls;
        bnd.chr_code  = s_data.char_code;
        bnd.pos       = offset_reg;
        bnd.line_post = line_post;
        bnd.end_v     = eoi;
        bnd.end_pos   = pos_inc;

        push      = accept && (bnd.run_v || bnd.chr_v || bnd.end_v);
        push_data = bnd;

        mode_next   = mode_reg;
        text_next   = text_reg;
        len_next    = len_reg;
        start_next  = start_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        if (accept) begin
            if (eoi) begin
                mode_next   = MODE_NONE;
                offset_next = '0;
                line_next   = '0;
            end else begin
                offset_next = pos_inc;
                line_next   = line_post;
                if (extend) begin
                    text_next = app_text;
                    len_next  = app_len;
                end else if (starts_run) begin
                    mode_next  = (cls == KIND_LETTER) ? MODE_ALNUM : MODE_DIGIT;
                    text_next  = TB'(s_data.char_code);
                    len_next   = 8'd1;
                    start_next = offset_reg;
                end else begin
                    mode_next = MODE_NONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NONE;
            offset_reg <= '0;
            line_reg   <= '0;
        end else begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
        end
    end

    always_ff @(posedge aclk) begin
        text_reg  <= text_next;
        len_reg   <= len_next;
        start_reg <= start_next;
    end

`ifndef SYNTHESIS
    a_eoi_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && eoi) |=> (offset_reg == '0 && line_reg == '0 && mode_reg == MODE_NONE))
        else $error("source end did not rewind position state");

    a_open_run_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_NONE) |-> (len_reg != 8'd0))
        else $error("open run with zero length");

    a_offset_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !eoi) |=> (offset_reg >= $past(offset_reg) && line_reg >= $past(line_reg)))
        else $error("position counter went backwards");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/asl_back.sv -----
// Lexer back end: keyword matching and serialization of bundles into token beats.
`default_nettype none

module asl_back #(
    parameter int TEXT_CHARS    = asl_pkg::TEXT_CHARS_DEF,
    parameter int POSITION_BITS = asl_pkg::POSITION_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [asl_pkg::bundle_bits(TEXT_CHARS, POSITION_BITS)-1:0] q_data,
    input  wire logic             q_empty,
    output      logic             q_pop,
    output      logic             m_valid,
    input  wire logic             m_ready,
    output      asl_pkg::asl_out_t m_data
);

    import asl_pkg::*;

    localparam int TB = TEXT_CHARS * 8;
    localparam int PB = POSITION_BITS;

    typedef struct packed {
        logic          run_v;
        logic          run_digit;
        logic [TB-1:0] run_text;
        logic [7:0]    run_len;
        logic [PB-1:0] run_start;
        logic [PB-1:0] run_end;
        logic [PB-1:0] line_pre;
        logic          chr_v;
        asl_kind_t     chr_kind;
        logic [7:0]    chr_code;
        logic [PB-1:0] pos;
        logic [PB-1:0] line_post;
        logic          end_v;
        logic [PB-1:0] end_pos;
    } bundle_t;

    // sent mask bits: run token, single-character token, end marker
    logic [2:0] sent_reg, sent_next;
    logic       m_valid_reg, m_valid_next;
    asl_out_t   m_data_reg, m_data_next;

    bundle_t    bnd;
    logic [2:0] pending, pick, remaining;
    logic       load, fire;
    asl_kind_t  run_kind;
    asl_out_t   tok;

    always_comb begin
        bnd = bundle_t'(q_data);

        pending = q_empty ? 3'b000 : ({bnd.end_v, bnd.chr_v, bnd.run_v} & ~sent_reg);
        if (pending[0]) begin
            pick = 3'b001;
        end else if (pending[1]) begin
            pick = 3'b010;
        end else begin
            pick = pending & 3'b100;
        end
        remaining = pending & ~pick;

        load  = !m_valid_reg || m_ready;
        fire  = load && !q_empty;
        q_pop = fire && (remaining == 3'b000);

        if (bnd.run_len == 8'd1) begin
            run_kind = classify_byte(bnd.run_text[7:0]);
        end else if (bnd.run_digit) begin
            run_kind = KIND_CONSTANT;
        end else if (is_opcode(bnd.run_text[31:0], bnd.run_len)) begin
            run_kind = KIND_OPCODE;
        end else if (is_register(bnd.run_text[31:0], bnd.run_len)) begin
            run_kind = KIND_REGISTER;
        end else begin
            run_kind = KIND_LABEL;
        end

        if (pick[0]) begin
            tok.token_kind   = run_kind;
            tok.token_text   = 64'(bnd.run_text);
            tok.token_length = bnd.run_len;
            tok.column_start = 16'(bnd.run_start);
            tok.column_end   = 16'(bnd.run_end);
            tok.line_number  = 16'(bnd.line_pre);
            tok.last_token   = 1'b0;
        end else if (pick[1]) begin
            tok.token_kind   = bnd.chr_kind;
            tok.token_text   = 64'(bnd.chr_code);
            tok.token_length = 8'd1;
            tok.column_start = 16'(bnd.pos);
            tok.column_end   = 16'(bnd.pos);
            tok.line_number  = 16'(bnd.line_post);
            tok.last_token   = 1'b0;
        end else begin
            tok.token_kind   = KIND_END;
            tok.token_text   = '0;
            tok.token_length = 8'd0;
            tok.column_start = 16'(bnd.end_pos);
            tok.column_end   = 16'(bnd.end_pos);
            tok.line_number  = 16'(bnd.line_post);
            tok.last_token   = 1'b1;
        end

        sent_next    = sent_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = !q_empty;
        end
        if (fire) begin
            m_data_next = tok;
            sent_next   = q_pop ? 3'b000 : (sent_reg | pick);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg    <= 3'b000;
            m_valid_reg <= 1'b0;
        end else begin
            sent_reg    <= sent_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_head_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_empty |-> (pending != 3'b000))
        else $error("queue head holds no unsent token");

    a_pop_with_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid_reg)
        else $error("bundle retired without a beat");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && pick[2]) |-> q_pop)
        else $error("end marker not the last beat of its bundle");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/assembly_source_lexer_top.sv -----
// Top level of the assembly source lexer: front end, bundle queue, back end.
//
//  channel   dir  handshake          beat payload
//  s_        in   s_valid/s_ready    asl_in_t : char_code, end_of_input
//  m_        out  m_valid/m_ready    asl_out_t: kind, text, length, columns, line, last
//
//  One source byte is taken per cycle while the bundle queue has room.
//  Each byte yields a bundle of zero to three tokens; the back end sends one
//  token beat per cycle while m_ready allows, so a byte with k tokens takes k beats.
//  A byte's bundle is written into the bundle queue, then its first token into the output register.
//  s_ready drops only when QUEUE_DEPTH bundles wait behind the output register.
//  Reset is synchronous on aresetn; no clearing pass.
`default_nettype none

module assembly_source_lexer_top #(
    parameter int TEXT_CHARS    = asl_pkg::TEXT_CHARS_DEF,
    parameter int POSITION_BITS = asl_pkg::POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH   = asl_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire asl_pkg::asl_in_t  s_data,
    output      logic              m_valid,
    input  wire logic              m_ready,
    output      asl_pkg::asl_out_t m_data
);

    import asl_pkg::*;

    // bundle: optional run token, optional one-character token, optional end marker
    localparam int BUNDLE_W = bundle_bits(TEXT_CHARS, POSITION_BITS);

    logic                push;
    logic [BUNDLE_W-1:0] push_data;
    logic                pop;
    logic [BUNDLE_W-1:0] head_data;
    logic                q_empty;
    logic                q_full;

    // Front: byte classify, run state, offsets and line count
    asl_front #(
        .TEXT_CHARS    (TEXT_CHARS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // Queue decouples byte intake from token output bursts
    asl_queue #(
        .WIDTH (BUNDLE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .rd_data   (head_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back: keyword match, token formatting, registered output beat
    asl_back #(
        .TEXT_CHARS    (TEXT_CHARS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_data  (head_data),
        .q_empty (q_empty),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
